>>> rtl/core/kvt_pkg.sv
// Shared types and codes for the key/value table.
`default_nettype none

package kvt_pkg;

   localparam int FIELD_WIDTH = 32;
   localparam int TOTAL_WIDTH = 5;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_LOOKUP = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STAT_DONE      = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_FULL      = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_SCAN = 2'd1,
      S_EXEC = 2'd2
   } state_type;

   typedef struct packed {
      logic [1:0]             opcode;
      logic [FIELD_WIDTH-1:0] key;
      logic [FIELD_WIDTH-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [FIELD_WIDTH-1:0] read_value;
      logic [TOTAL_WIDTH-1:0] entry_total;
      logic                   is_empty;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic issue;
      logic scan;
      logic exec;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic issue_done;
      logic cmp_hit;
      logic cmp_last;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

>>> rtl/core/kvt_ctrl.sv
// Sequencer for the key/value table: accept, scan, execute.
`default_nettype none

module kvt_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire kvt_pkg::dp_status_type dp_status,
   output kvt_pkg::cmd_type            cmd
);

   kvt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kvt_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         kvt_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = kvt_pkg::S_SCAN;
            end
         end
         kvt_pkg::S_SCAN: begin
            cmd.scan  = 1'b1;
            cmd.issue = !dp_status.issue_done;
            // stop on the matching slot or after the last slot is compared
            if (dp_status.cmp_hit || dp_status.cmp_last) begin
               state_in = kvt_pkg::S_EXEC;
            end
         end
         kvt_pkg::S_EXEC: begin
            // hold until the result register can take a beat
            if (dp_status.out_free) begin
               cmd.exec = 1'b1;
               state_in = kvt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = kvt_pkg::S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/core/kvt_dpath.sv
// Datapath for the key/value table: slot storage, scan compare, result register.
`default_nettype none

module kvt_dpath #(
   parameter int TABLE_DEPTH = 16,
   parameter int KEY_WIDTH   = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire kvt_pkg::req_type       req_data,
   input  wire kvt_pkg::cmd_type       cmd,
   output kvt_pkg::dp_status_type      dp_status,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output kvt_pkg::rsp_type            rsp_data
);

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

   logic [KEY_WIDTH-1:0]   key_mem   [TABLE_DEPTH];
   logic [VALUE_WIDTH-1:0] value_mem [TABLE_DEPTH];

   logic [1:0]             op_ff, op_in;
   logic [KEY_WIDTH-1:0]   key_ff, key_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [IW-1:0]          rd_idx_ff, rd_idx_in;
   logic                   issue_done_ff, issue_done_in;
   logic                   cmp_live_ff, cmp_live_in;
   logic [IW-1:0]          cmp_idx_ff, cmp_idx_in;
   logic [KEY_WIDTH-1:0]   key_rd_ff;
   logic [VALUE_WIDTH-1:0] val_rd_ff;
   logic                   hit_ff, hit_in;
   logic [IW-1:0]          hit_idx_ff, hit_idx_in;
   logic [VALUE_WIDTH-1:0] hit_val_ff, hit_val_in;
   logic                   free_ff, free_in;
   logic [IW-1:0]          free_idx_ff, free_idx_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [CW-1:0]          count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   kvt_pkg::rsp_type       rsp_ff, rsp_in;

   logic                   wr_key;
   logic                   wr_value;
   logic [IW-1:0]          wr_idx;
   logic [1:0]             status;
   logic [VALUE_WIDTH-1:0] read_val;
   logic                   cmp_hit;
   logic                   out_free;

   assign cmp_hit  = cmp_live_ff && valid_ff[cmp_idx_ff] && (key_rd_ff == key_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign dp_status.issue_done = issue_done_ff;
   assign dp_status.cmp_hit    = cmp_hit;
   assign dp_status.cmp_last   = cmp_live_ff && (cmp_idx_ff == LAST_IDX);
   assign dp_status.out_free   = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      op_in         = op_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      rd_idx_in     = rd_idx_ff;
      issue_done_in = issue_done_ff;
      cmp_live_in   = cmd.issue;
      cmp_idx_in    = cmp_idx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_val_in    = hit_val_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      wr_key        = 1'b0;
      wr_value      = 1'b0;
      wr_idx        = hit_idx_ff;
      status        = kvt_pkg::STAT_DONE;
      read_val      = '0;

      if (cmd.load) begin
         op_in         = req_data.opcode;
         key_in        = KEY_WIDTH'(req_data.key);
         value_in      = VALUE_WIDTH'(req_data.value);
         rd_idx_in     = '0;
         issue_done_in = 1'b0;
         hit_in        = 1'b0;
         free_in       = 1'b0;
      end

      if (cmd.issue) begin
         cmp_idx_in    = rd_idx_ff;
         rd_idx_in     = rd_idx_ff + 1'b1;
         issue_done_in = (rd_idx_ff == LAST_IDX);
      end

      if (cmd.scan && cmp_live_ff) begin
         if (cmp_hit) begin
            hit_in     = 1'b1;
            hit_idx_in = cmp_idx_ff;
            hit_val_in = val_rd_ff;
         end
         // keep the lowest free slot
         if (!valid_ff[cmp_idx_ff] && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = cmp_idx_ff;
         end
      end

      if (cmd.exec) begin
         unique case (op_ff)
            kvt_pkg::OP_INSERT: begin
               if (hit_ff) begin
                  wr_value = 1'b1;
               end else if (free_ff) begin
                  wr_key               = 1'b1;
                  wr_value             = 1'b1;
                  wr_idx               = free_idx_ff;
                  valid_in[free_idx_ff] = 1'b1;
                  count_in             = count_ff + 1'b1;
               end else begin
                  status = kvt_pkg::STAT_FULL;
               end
            end
            kvt_pkg::OP_DELETE: begin
               if (hit_ff) begin
                  valid_in[hit_idx_ff] = 1'b0;
                  count_in             = count_ff - 1'b1;
               end else begin
                  status = kvt_pkg::STAT_NOT_FOUND;
               end
            end
            kvt_pkg::OP_LOOKUP: begin
               if (hit_ff) begin
                  read_val = hit_val_ff;
               end else begin
                  status = kvt_pkg::STAT_NOT_FOUND;
               end
            end
            default: begin
            end
         endcase
      end

      rsp_in.status      = status;
      rsp_in.read_value  = kvt_pkg::FIELD_WIDTH'(read_val);
      rsp_in.entry_total = kvt_pkg::TOTAL_WIDTH'(count_in);
      rsp_in.is_empty    = (count_in == '0);

      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_done_ff <= 1'b0;
         cmp_live_ff   <= 1'b0;
         hit_ff        <= 1'b0;
         free_ff       <= 1'b0;
         valid_ff      <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         issue_done_ff <= issue_done_in;
         cmp_live_ff   <= cmp_live_in;
         hit_ff        <= hit_in;
         free_ff       <= free_in;
         valid_ff      <= valid_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      value_ff    <= value_in;
      rd_idx_ff   <= rd_idx_in;
      cmp_idx_ff  <= cmp_idx_in;
      hit_idx_ff  <= hit_idx_in;
      hit_val_ff  <= hit_val_in;
      free_idx_ff <= free_idx_in;
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end
   end

   // slot storage: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_key) begin
         key_mem[wr_idx] <= key_ff;
      end
      if (wr_value) begin
         value_mem[wr_idx] <= value_ff;
      end
      key_rd_ff <= key_mem[rd_idx_ff];
      val_rd_ff <= value_mem[rd_idx_ff];
   end

endmodule

`default_nettype wire

>>> rtl/core/key_value_table.sv
// Top level of the key/value table: controller, datapath and port checks.
//
//   channel | direction | beat payload       | handshake
//   --------+-----------+--------------------+-----------------------
//   req     | in        | kvt_pkg::req_type  | req_valid / req_stall
//   rsp     | out       | kvt_pkg::rsp_type  | rsp_valid / rsp_stall
//
// One operation at a time. A request beat is taken, then the slots are
// compared one per cycle through the single read port of the key store,
// stopping on the matching slot or after the last slot; the update is then
// applied once the result register can take a beat.
// Reset clears the valid bits, the entry count and the result valid flag;
// key and value stores are left as they are and are never used unless valid.
// A stalled result holds in its register while the next request is scanned.
`default_nettype none

module key_value_table #(
   parameter int TABLE_DEPTH = 16,
   parameter int KEY_WIDTH   = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire kvt_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output kvt_pkg::rsp_type      rsp_data
);

   kvt_pkg::cmd_type       cmd;
   kvt_pkg::dp_status_type dp_status;

   // sequence each operation: accept, scan slots, execute
   kvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   // hold slots, compare keys, drive the result beat
   kvt_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_WIDTH   (KEY_WIDTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .dp_status (dp_status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // a taken request beat blocks the next one until it has been executed
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while another operation is in flight");

   // executing an operation always presents a result beat
   a_exec_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> rsp_valid)
      else $error("executed operation produced no result beat");

   // an empty table reports a zero entry total
   a_empty_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_empty |-> rsp_data.entry_total == '0)
      else $error("empty flag set with non-zero entry total");

   // no execution while the scan is still comparing slots
   a_exec_after_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> !cmd.scan && !cmd.issue)
      else $error("execute overlapped the slot scan");

endmodule

`default_nettype wire

>>> tb/sv/tb_key_value_table.sv
// Self-checking testbench for the key/value table: directed table, then random traffic.
`timescale 1ns / 100ps

module tb_key_value_table;

   localparam int         DEPTH       = 16;
   localparam int         RANDOM_OPS  = 800;
   localparam int         KEY_POOL    = 24;
   // Slowest turn-around of one operation, plus a little slack for the tail.
   localparam int         OP_CYCLES   = DEPTH + 3;
   localparam int         TAIL_CYCLES = 2 * OP_CYCLES + 8;
   localparam int         HOLD_CYCLES = 400;
   // The spare opcode does nothing, but the field allows it.
   localparam logic [1:0] OP_NOOP     = 2'd3;

   // A row of the directed table. Rows with typed_in set carry a result that
   // can be read off by eye; the rest are checked against the table model.
   typedef struct {
      logic [1:0]       opcode;
      logic [31:0]      key;
      logic [31:0]      value;
      int               repeats;
      bit               typed_in;
      kvt_pkg::rsp_type outcome;
   } plan_row_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   kvt_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   kvt_pkg::rsp_type rsp_data;

   // Model of the table contents, updated as each request beat is taken.
   bit          model_valid [DEPTH];
   logic [31:0] model_key   [DEPTH];
   logic [31:0] model_value [DEPTH];
   int          model_count;
   int          peak_count;

   kvt_pkg::rsp_type awaited_rsp [$];
   plan_row_type     plan        [$];
   logic [31:0]      key_pool    [KEY_POOL];

   int errors      = 0;
   int req_taken   = 0;
   int rsp_seen    = 0;
   int seen_done   = 0;
   int seen_absent = 0;
   int seen_full   = 0;

   key_value_table #(
      .TABLE_DEPTH (DEPTH),
      .KEY_WIDTH   (32),
      .VALUE_WIDTH (32)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   // Hard stop in case the block hangs.
   initial begin
      #4_000_000;
      $display("%0t: timeout, %0d results still awaited", $time, awaited_rsp.size());
      $display("tb_key_value_table NOT OK");
      $finish;
   end

   // Apply one operation to the model and return the result it should give.
   function automatic kvt_pkg::rsp_type apply_op(input kvt_pkg::req_type beat);
      kvt_pkg::rsp_type outcome;
      int               hit;
      int               free_slot;
      outcome        = '0;
      outcome.status = kvt_pkg::STAT_DONE;
      hit            = -1;
      free_slot      = -1;
      // Parallel compare and lowest-free-slot search, done as one sweep.
      for (int i = 0; i < DEPTH; i++) begin
         if (hit < 0 && model_valid[i] && model_key[i] == beat.key)
            hit = i;
         if (free_slot < 0 && !model_valid[i])
            free_slot = i;
      end
      case (beat.opcode)
         kvt_pkg::OP_INSERT: begin
            if (hit >= 0) begin
               model_value[hit] = beat.value;
            end else if (free_slot >= 0) begin
               model_valid[free_slot] = 1'b1;
               model_key[free_slot]   = beat.key;
               model_value[free_slot] = beat.value;
               model_count++;
            end else begin
               outcome.status = kvt_pkg::STAT_FULL;
            end
         end
         kvt_pkg::OP_DELETE: begin
            if (hit >= 0) begin
               model_valid[hit] = 1'b0;
               model_count--;
            end else begin
               outcome.status = kvt_pkg::STAT_NOT_FOUND;
            end
         end
         kvt_pkg::OP_LOOKUP: begin
            if (hit >= 0)
               outcome.read_value = model_value[hit];
            else
               outcome.status = kvt_pkg::STAT_NOT_FOUND;
         end
         default: ;   // spare opcode: leave the table alone
      endcase
      if (model_count > peak_count)
         peak_count = model_count;
      outcome.entry_total = 5'(model_count);
      outcome.is_empty    = (model_count == 0);
      return outcome;
   endfunction

   function automatic plan_row_type row(input logic [1:0] opcode, input logic [31:0] key,
                                        input logic [31:0] value, input int repeats,
                                        input bit typed_in,
                                        input kvt_pkg::status_type status,
                                        input logic [31:0] read_value, input int total,
                                        input bit is_empty);
      plan_row_type r;
      r.opcode              = opcode;
      r.key                 = key;
      r.value               = value;
      r.repeats             = repeats;
      r.typed_in            = typed_in;
      r.outcome.status      = status;
      r.outcome.read_value  = read_value;
      r.outcome.entry_total = 5'(total);
      r.outcome.is_empty    = is_empty;
      return r;
   endfunction

   // Request side idle cycles: none in some stretches, drawn at random elsewhere.
   function automatic int req_gap();
      if ((req_taken / 64) % 5 == 3)
         return 0;
      return $urandom_range(0, 17);
   endfunction

   // Offer one request beat after an idle gap and hold it until taken. When
   // the gap is zero, valid simply stays high for the next beat.
   task automatic offer(input kvt_pkg::req_type beat, input bit typed_in,
                        input kvt_pkg::rsp_type typed_rsp);
      kvt_pkg::rsp_type predicted;
      int               gap;
      gap = req_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
      req_taken++;
      // The model always advances; typed rows override only what is awaited.
      predicted = apply_op(beat);
      awaited_rsp.push_back(typed_in ? typed_rsp : predicted);
   endtask

   task automatic check_field(input string name, input logic [31:0] expected,
                              input logic [31:0] actual);
      if (expected !== actual) begin
         errors++;
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                  $time, name, expected, actual);
      end
   endtask

   // Result monitor: take each accepted beat against the oldest awaited one.
   always @(posedge clock) begin
      kvt_pkg::rsp_type expected;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         case (rsp_data.status)
            kvt_pkg::STAT_DONE:      seen_done++;
            kvt_pkg::STAT_NOT_FOUND: seen_absent++;
            kvt_pkg::STAT_FULL:      seen_full++;
            default: ;
         endcase
         if (awaited_rsp.size() == 0) begin
            errors++;
            $display("%0t: result beat with nothing awaited, got 0x%0h", $time, rsp_data);
         end else begin
            expected = awaited_rsp.pop_front();
            check_field("status", 32'(expected.status), 32'(rsp_data.status));
            check_field("read_value", expected.read_value, rsp_data.read_value);
            check_field("entry_total", 32'(expected.entry_total), 32'(rsp_data.entry_total));
            check_field("is_empty", 32'(expected.is_empty), 32'(rsp_data.is_empty));
         end
      end
   end

   // Result side back-pressure. Stall for a random count before each beat,
   // drop it in quiet stretches, and twice hold off for a long stretch so the
   // result register fills and the block has to stall its request side.
   initial begin
      int stall_cycles;
      int next_hold;
      next_hold = 150;
      @(negedge reset);
      @(posedge clock);
      forever begin
         if (rsp_seen >= next_hold && next_hold < 600) begin
            next_hold    = next_hold + 350;
            stall_cycles = HOLD_CYCLES;
         end else if ((rsp_seen / 50) % 5 == 1) begin
            stall_cycles = 0;
         end else begin
            stall_cycles = $urandom_range(0, 17);
         end
         if (stall_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      kvt_pkg::req_type beat;
      kvt_pkg::rsp_type none;
      int               phase;
      int               pick;
      int               drain;

      none        = '0;
      model_count = 0;
      peak_count  = 0;
      foreach (model_valid[i]) begin
         model_valid[i] = 1'b0;
         model_key[i]   = '0;
         model_value[i] = '0;
      end
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < KEY_POOL; i++)
         key_pool[i] = $urandom();

      // Directed table: empty-table cases, extremes, update, head deletion,
      // fill to capacity, then the full-table cases.
      plan.push_back(row(kvt_pkg::OP_LOOKUP, 32'h0, 32'h0, 1, 1,
                         kvt_pkg::STAT_NOT_FOUND, 32'h0, 0, 1));
      plan.push_back(row(kvt_pkg::OP_DELETE, 32'h5, 32'h0, 1, 1,
                         kvt_pkg::STAT_NOT_FOUND, 32'h0, 0, 1));
      plan.push_back(row(OP_NOOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1,
                         kvt_pkg::STAT_DONE, 32'h0, 0, 1));
      plan.push_back(row(kvt_pkg::OP_INSERT, 32'h0, 32'hFFFF_FFFF, 1, 1,
                         kvt_pkg::STAT_DONE, 32'h0, 1, 0));
      plan.push_back(row(kvt_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'h0, 1, 1,
                         kvt_pkg::STAT_DONE, 32'h0, 2, 0));
      plan.push_back(row(kvt_pkg::OP_LOOKUP, 32'h0, 32'h0, 1, 1,
                         kvt_pkg::STAT_DONE, 32'hFFFF_FFFF, 2, 0));
      plan.push_back(row(kvt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h1, 1, 1,
                         kvt_pkg::STAT_DONE, 32'h0, 2, 0));
      plan.push_back(row(kvt_pkg::OP_INSERT, 32'h0, 32'h1234_5678, 1, 1,
                         kvt_pkg::STAT_DONE, 32'h0, 2, 0));
      plan.push_back(row(kvt_pkg::OP_LOOKUP, 32'h0, 32'h0, 1, 1,
                         kvt_pkg::STAT_DONE, 32'h1234_5678, 2, 0));
      plan.push_back(row(kvt_pkg::OP_DELETE, 32'h0, 32'h0, 1, 1,
                         kvt_pkg::STAT_DONE, 32'h0, 1, 0));
      plan.push_back(row(kvt_pkg::OP_LOOKUP, 32'h0, 32'h0, 1, 1,
                         kvt_pkg::STAT_NOT_FOUND, 32'h0, 1, 0));
      plan.push_back(row(kvt_pkg::OP_INSERT, 32'h1000, 32'hA5A5_A5A5, 15, 0,
                         kvt_pkg::STAT_DONE, 32'h0, 0, 0));
      plan.push_back(row(kvt_pkg::OP_INSERT, 32'h7, 32'h77, 1, 1,
                         kvt_pkg::STAT_FULL, 32'h0, 16, 0));
      plan.push_back(row(kvt_pkg::OP_LOOKUP, 32'h7, 32'h0, 1, 1,
                         kvt_pkg::STAT_NOT_FOUND, 32'h0, 16, 0));
      plan.push_back(row(kvt_pkg::OP_INSERT, 32'h100A, 32'h5A5A_5A5A, 1, 0,
                         kvt_pkg::STAT_DONE, 32'h0, 0, 0));
      plan.push_back(row(kvt_pkg::OP_LOOKUP, 32'h100A, 32'h0, 1, 0,
                         kvt_pkg::STAT_DONE, 32'h0, 0, 0));
      plan.push_back(row(OP_NOOP, 32'h0, 32'h0, 1, 1,
                         kvt_pkg::STAT_DONE, 32'h0, 16, 0));
      plan.push_back(row(kvt_pkg::OP_DELETE, 32'hFFFF_FFFF, 32'h0, 1, 0,
                         kvt_pkg::STAT_DONE, 32'h0, 0, 0));
      plan.push_back(row(kvt_pkg::OP_INSERT, 32'h7, 32'h77, 1, 0,
                         kvt_pkg::STAT_DONE, 32'h0, 0, 0));
      plan.push_back(row(kvt_pkg::OP_DELETE, 32'h7, 32'h0, 1, 1,
                         kvt_pkg::STAT_DONE, 32'h0, 15, 0));
      plan.push_back(row(kvt_pkg::OP_DELETE, 32'h7, 32'h0, 1, 1,
                         kvt_pkg::STAT_NOT_FOUND, 32'h0, 15, 0));

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the table; repeated rows step key and value on each beat.
      foreach (plan[r]) begin
         for (int n = 0; n < plan[r].repeats; n++) begin
            beat.opcode = plan[r].opcode;
            beat.key    = plan[r].key + n;
            beat.value  = plan[r].value + n;
            offer(beat, plan[r].typed_in, plan[r].outcome);
         end
      end

      // Random traffic in phases: filling, draining, then mixed. Keys come
      // mostly from a small pool so hits, updates and a full table happen.
      for (int i = 0; i < RANDOM_OPS; i++) begin
         phase = (i / 80) % 3;
         pick  = $urandom_range(0, 99);
         if (pick < 5)
            beat.opcode = OP_NOOP;
         else if (phase == 0)
            beat.opcode = (pick < 65) ? kvt_pkg::OP_INSERT :
                          (pick < 80) ? kvt_pkg::OP_DELETE : kvt_pkg::OP_LOOKUP;
         else if (phase == 1)
            beat.opcode = (pick < 25) ? kvt_pkg::OP_INSERT :
                          (pick < 75) ? kvt_pkg::OP_DELETE : kvt_pkg::OP_LOOKUP;
         else
            beat.opcode = (pick < 40) ? kvt_pkg::OP_INSERT :
                          (pick < 65) ? kvt_pkg::OP_DELETE : kvt_pkg::OP_LOOKUP;
         beat.key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, KEY_POOL - 1)]
                                                 : $urandom();
         case ($urandom_range(0, 9))
            0:       beat.value = 32'h0;
            1:       beat.value = 32'hFFFF_FFFF;
            default: beat.value = $urandom();
         endcase
         offer(beat, 1'b0, none);
      end
      req_valid <= 1'b0;

      // Wait for the last results, then a quiet tail to catch strays.
      drain = 0;
      while (awaited_rsp.size() != 0 && drain < 20_000) begin
         @(posedge clock);
         drain++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (awaited_rsp.size() != 0) begin
         errors++;
         $display("%0t: %0d results never arrived", $time, awaited_rsp.size());
      end

      $display("Ran %0d operations, %0d results: %0d done, %0d key absent, %0d table full.",
               req_taken, rsp_seen, seen_done, seen_absent, seen_full);
      $display("Peak occupancy %0d of %0d slots; %0d mismatches.", peak_count, DEPTH, errors);
      if (errors == 0)
         $display("tb_key_value_table OK");
      else
         $display("tb_key_value_table NOT OK");
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/kvt_pkg.sv
rtl/core/kvt_ctrl.sv
rtl/core/kvt_dpath.sv
rtl/core/key_value_table.sv
tb/sv/tb_key_value_table.sv
